FILE: design/pfe_pkg.sv
// Package for the postfix expression evaluator.
// Character codes, cell control and shared types. No dependencies.
package pfe_pkg;

    localparam logic [7:0] SYM_ADD  = 8'h2B;
    localparam logic [7:0] SYM_SUB  = 8'h2D;
    localparam logic [7:0] SYM_MUL  = 8'h2A;
    localparam logic [7:0] SYM_DIV  = 8'h2F;
    localparam logic [7:0] SYM_ZERO = 8'h30;

    localparam int RESULT_WIDTH = 32;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_PREV,
        CELL_TAKE_NEXT
    } cell_mode_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

endpackage

FILE: design/pfe_cell.sv
// One stack cell: holds a single entry, shifts towards or away from the top.
// Depends on pfe_pkg.
module pfe_cell #(
    parameter int W = 32
) (
    input  logic               clk,
    input  pfe_pkg::cell_mode_t mode,
    input  logic [W-1:0]       prev_value,
    input  logic [W-1:0]       next_value,
    output logic [W-1:0]       value
);
    import pfe_pkg::*;

    logic [W-1:0] value_reg;
    logic [W-1:0] value_next;

    always_comb
    begin
        unique case (mode)
            CELL_TAKE_PREV: value_next = prev_value;
            CELL_TAKE_NEXT: value_next = next_value;
            default:        value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: design/pfe_muldiv.sv
// Shared bit-serial multiply and signed truncating divide, one bit per cycle.
// Depends on pfe_pkg.
module pfe_muldiv #(
    parameter int W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pfe_pkg::md_req_t req,
    input  logic [W-1:0]     a,
    input  logic [W-1:0]     b,
    output logic             done,
    output logic             zero_div,
    output logic [W-1:0]     result
);
    import pfe_pkg::*;

    localparam int SW = (W > 1) ? $clog2(W) : 1;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIN
    } md_state_t;

    md_state_t     state_reg;
    logic [SW-1:0] step_reg;
    logic          is_div_reg;
    logic          neg_reg;
    logic [W-1:0]  x_reg;
    logic [W-1:0]  y_reg;
    logic [W:0]    acc_reg;
    logic          done_reg;
    logic          zd_reg;
    logic [W-1:0]  res_reg;

    logic [W-1:0]  mag_a;
    logic [W-1:0]  mag_b;
    logic [W:0]    rem_shift;
    logic [W:0]    diff;
    logic [W-1:0]  acc_sum;

    always_comb
    begin
        mag_a     = a[W-1] ? (W'(0) - a) : a;
        mag_b     = b[W-1] ? (W'(0) - b) : b;
        rem_shift = {acc_reg[W-1:0], x_reg[W-1]};
        diff      = rem_shift - {1'b0, y_reg};
        acc_sum   = acc_reg[W-1:0] + y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= MD_IDLE;
            step_reg   <= '0;
            is_div_reg <= 1'b0;
            neg_reg    <= 1'b0;
            x_reg      <= '0;
            y_reg      <= '0;
            acc_reg    <= '0;
            done_reg   <= 1'b0;
            zd_reg     <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                MD_IDLE:
                begin
                    if (req.start)
                    begin
                        is_div_reg <= req.is_div;
                        step_reg   <= SW'(W - 1);
                        acc_reg    <= '0;
                        zd_reg     <= 1'b0;
                        if (req.is_div)
                        begin
                            if (b == '0)
                            begin
                                x_reg     <= '0;
                                neg_reg   <= 1'b0;
                                zd_reg    <= 1'b1;
                                state_reg <= MD_FIN;
                            end
                            else
                            begin
                                x_reg     <= mag_a;
                                y_reg     <= mag_b;
                                neg_reg   <= a[W-1] ^ b[W-1];
                                state_reg <= MD_RUN;
                            end
                        end
                        else
                        begin
                            x_reg     <= a;
                            y_reg     <= b;
                            neg_reg   <= 1'b0;
                            state_reg <= MD_RUN;
                        end
                    end
                end
                MD_RUN:
                begin
                    if (is_div_reg)
                    begin
                        if (!diff[W])
                        begin
                            acc_reg <= diff;
                            x_reg   <= {x_reg[W-2:0], 1'b1};
                        end
                        else
                        begin
                            acc_reg <= rem_shift;
                            x_reg   <= {x_reg[W-2:0], 1'b0};
                        end
                    end
                    else
                    begin
                        if (x_reg[0])
                        begin
                            acc_reg <= {1'b0, acc_sum};
                        end
                        x_reg <= {1'b0, x_reg[W-1:1]};
                        y_reg <= {y_reg[W-2:0], 1'b0};
                    end
                    if (step_reg == '0)
                    begin
                        state_reg <= MD_FIN;
                    end
                    else
                    begin
                        step_reg <= step_reg - SW'(1);
                    end
                end
                MD_FIN:
                begin
                    if (is_div_reg)
                    begin
                        res_reg <= neg_reg ? (W'(0) - x_reg) : x_reg;
                    end
                    else
                    begin
                        res_reg <= acc_reg[W-1:0];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= MD_IDLE;
                end
                default:
                begin
                    state_reg <= MD_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign zero_div = zd_reg;
    assign result   = res_reg;

endmodule

FILE: design/postfix_expression_evaluator.sv
// Top level of the postfix expression evaluator.
// Depends on pfe_pkg, pfe_cell and pfe_muldiv.
//
// Input stream: one character per transaction. s_axis_tdata[7:0] is the
// character, s_axis_tlast marks the terminator (character ignored).
// Output stream: one transaction per terminator. m_axis_tdata is the popped
// value (-1 if the stack was empty), m_axis_tuser carries the sticky flags.
// The stack is a row of cells, top of stack in cell 0; a push shifts the
// row down, an operator loads cell 0 and shifts the rest up.
// Digits, other characters, + and - do not stall the input. * and / run on a
// shared bit-serial unit, one bit per cycle: s_axis_tready is low while the
// unit is busy, from after the * or / transaction until its result is written
// back to cell 0, also for a zero divisor.
// A terminator's result is registered into one of two output slots that sit
// between the sides, so characters keep flowing while a result waits;
// input also stalls while both slots are full.
// Reset empties the stack, clears the flags and drops pending results.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,   // end_of_expression
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result_value
    output logic [2:0]  m_axis_tuser    // [0] stack_underflow, [1] stack_overflow,
                                        // [2] divide_by_zero
);
    import pfe_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [VALUE_WIDTH-1:0] cell_value [STACK_DEPTH];
    cell_mode_t             cell_mode  [STACK_DEPTH];

    logic [CW-1:0] count_reg;
    logic          uf_reg;
    logic          of_reg;
    logic          dz_reg;
    logic          busy_reg;
    logic          out_valid_reg;
    logic          skid_valid_reg;
    logic [31:0]   out_data_reg;
    logic [2:0]    out_user_reg;
    logic [31:0]   skid_data_reg;
    logic [2:0]    skid_user_reg;

    logic                   in_take;
    logic                   out_take;
    logic                   is_op;
    logic                   is_muldiv;
    logic                   has_one;
    logic                   has_two;
    logic                   full;
    logic [VALUE_WIDTH-1:0] rhs;
    logic [VALUE_WIDTH-1:0] lhs;
    logic [VALUE_WIDTH-1:0] digit_value;
    logic [VALUE_WIDTH-1:0] addsub_value;
    logic [VALUE_WIDTH-1:0] new_value;
    logic                   commit_op;
    logic                   do_push;
    logic                   do_emit;
    logic [31:0]            emit_data;
    logic [2:0]             emit_user;

    md_req_t                md_req;
    logic                   md_done;
    logic                   md_zero_div;
    logic [VALUE_WIDTH-1:0] md_result;

    always_comb
    begin
        in_take      = s_axis_tvalid && s_axis_tready;
        out_take     = m_axis_tvalid && m_axis_tready;
        is_muldiv    = (s_axis_tdata == SYM_MUL) || (s_axis_tdata == SYM_DIV);
        is_op        = is_muldiv || (s_axis_tdata == SYM_ADD) || (s_axis_tdata == SYM_SUB);
        has_one      = count_reg != '0;
        has_two      = count_reg > CW'(1);
        full         = count_reg == CW'(STACK_DEPTH);
        rhs          = has_one ? cell_value[0] : '1;
        lhs          = has_two ? cell_value[1] : '1;
        digit_value  = VALUE_WIDTH'(s_axis_tdata) - VALUE_WIDTH'(SYM_ZERO);
        addsub_value = (s_axis_tdata == SYM_ADD) ? (lhs + rhs) : (lhs - rhs);
        new_value    = md_done ? md_result : (is_op ? addsub_value : digit_value);

        md_req.start  = in_take && !s_axis_tlast && is_muldiv;
        md_req.is_div = s_axis_tdata == SYM_DIV;

        commit_op = md_done || (in_take && !s_axis_tlast && is_op && !is_muldiv);
        do_push   = in_take && !s_axis_tlast && !is_op && !full;
        do_emit   = in_take && s_axis_tlast;

        emit_data = 32'(signed'(rhs));
        emit_user = {dz_reg, of_reg, uf_reg || !has_one};
    end

    always_comb
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            priority if (commit_op)
            begin
                if (i == 0)
                    cell_mode[i] = CELL_TAKE_PREV;
                else
                    cell_mode[i] = has_two ? CELL_TAKE_NEXT : CELL_HOLD;
            end
            else if (do_push)
            begin
                cell_mode[i] = CELL_TAKE_PREV;
            end
            else
            begin
                cell_mode[i] = CELL_HOLD;
            end
        end
    end

    for (genvar g = 0; g < STACK_DEPTH; g++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] prev_in;
        logic [VALUE_WIDTH-1:0] next_in;

        if (g == 0)
        begin : g_first
            assign prev_in = new_value;
        end
        else
        begin : g_mid
            assign prev_in = cell_value[g-1];
        end

        if (g == STACK_DEPTH - 1)
        begin : g_last
            assign next_in = '0;
        end
        else
        begin : g_inner
            assign next_in = cell_value[g+1];
        end

        pfe_cell #(
            .W (VALUE_WIDTH)
        ) u_cell (
            .clk        (clk),
            .mode       (cell_mode[g]),
            .prev_value (prev_in),
            .next_value (next_in),
            .value      (cell_value[g])
        );
    end

    pfe_muldiv #(
        .W (VALUE_WIDTH)
    ) u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (md_req),
        .a        (lhs),
        .b        (rhs),
        .done     (md_done),
        .zero_div (md_zero_div),
        .result   (md_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            uf_reg         <= 1'b0;
            of_reg         <= 1'b0;
            dz_reg         <= 1'b0;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (md_req.start)
            begin
                busy_reg <= 1'b1;
            end
            if (md_done)
            begin
                busy_reg <= 1'b0;
                if (md_zero_div)
                    dz_reg <= 1'b1;
            end
            if (in_take && !s_axis_tlast && is_op && !has_two)
            begin
                uf_reg <= 1'b1;
            end
            if (commit_op)
            begin
                count_reg <= has_two ? (count_reg - CW'(1)) : CW'(1);
            end
            if (in_take && !s_axis_tlast && !is_op)
            begin
                if (full)
                    of_reg <= 1'b1;
                else
                    count_reg <= count_reg + CW'(1);
            end
            if (do_emit)
            begin
                count_reg <= '0;
                uf_reg    <= 1'b0;
                of_reg    <= 1'b0;
                dz_reg    <= 1'b0;
            end

            if (out_take)
            begin
                if (skid_valid_reg)
                    skid_valid_reg <= 1'b0;
                else
                    out_valid_reg <= 1'b0;
            end
            if (do_emit)
            begin
                if (!out_valid_reg || (out_take && !skid_valid_reg))
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
            out_user_reg <= skid_user_reg;
        end
        if (do_emit)
        begin
            if (!out_valid_reg || (out_take && !skid_valid_reg))
            begin
                out_data_reg <= emit_data;
                out_user_reg <= emit_user;
            end
            else
            begin
                skid_data_reg <= emit_data;
                skid_user_reg <= emit_user;
            end
        end
    end

    assign s_axis_tready = !busy_reg && !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !s_axis_tready)
        else $error("input accepted while multiply or divide in progress");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_terminator_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast)
        |=> (count_reg == '0) && !uf_reg && !of_reg && !dz_reg && m_axis_tvalid)
        else $error("terminator did not clear state or emit a result");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot filled while output slot empty");

    a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> busy_reg)
        else $error("arithmetic unit finished with no operation pending");

endmodule
